FILE: rtl/mrfc_pkg.sv
// ----------------------------------------------------------------------------
// Modbus RTU frame checker package
// Shared widths, CRC constants, status codes, the input beat type and the
// per-byte CRC-16 update.
// ----------------------------------------------------------------------------
package mrfc_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 256;

  localparam int unsigned DATA_W  = 8;
  localparam int unsigned LEN_W   = 9;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned CRC_W   = 16;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

  typedef enum logic [1:0] {
    STATUS_GOOD    = 2'd0,
    STATUS_LEN_ERR = 2'd1,
    STATUS_CRC_ERR = 2'd2
  } status_t;

  typedef struct packed {
    logic [DATA_W-1:0] rx_byte;
    logic              frame_end;
    logic [LEN_W-1:0]  expected_length;
  } beat_t;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [DATA_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-DATA_W){1'b0}}, b};
    for (int k = 0; k < DATA_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/mrfc_in_reg.sv
// ----------------------------------------------------------------------------
// Modbus RTU frame checker input register
// Captures one received beat and holds it until the evaluation stage takes it.
// ----------------------------------------------------------------------------
module mrfc_in_reg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mrfc_pkg::DATA_W-1:0]  in_rx_byte,
  input  logic                         in_frame_end,
  input  logic [mrfc_pkg::LEN_W-1:0]   in_expected_length,
  input  logic                         beat_go,
  output logic                         beat_valid,
  output mrfc_pkg::beat_t              beat
);

  logic            valid_r;
  logic            valid_nxt;
  mrfc_pkg::beat_t beat_r;
  logic            accept;

  assign in_stall = valid_r && !beat_go;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (beat_go) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      beat_r.rx_byte         <= in_rx_byte;
      beat_r.frame_end       <= in_frame_end;
      beat_r.expected_length <= in_expected_length;
    end
  end

  assign beat_valid = valid_r;
  assign beat       = beat_r;

endmodule

FILE: rtl/mrfc_frame_eval.sv
// ----------------------------------------------------------------------------
// Modbus RTU frame checker evaluation stage
// Runs the CRC over delayed bytes, counts the frame and registers one status
// beat on the last byte of each frame.
// ----------------------------------------------------------------------------
module mrfc_frame_eval #(
  parameter int unsigned MAX_FRAME_BYTES = mrfc_pkg::MAX_FRAME_BYTES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          beat_valid,
  input  mrfc_pkg::beat_t               beat,
  output logic                          beat_go,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [mrfc_pkg::CRC_W-1:0]    out_computed_crc,
  output logic [mrfc_pkg::COUNT_W-1:0]  out_byte_count
);

  localparam int unsigned CW   = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned CMPW = (CW > mrfc_pkg::LEN_W) ? CW : mrfc_pkg::LEN_W;

  logic [mrfc_pkg::CRC_W-1:0]  crc_r,  crc_nxt;
  logic [mrfc_pkg::DATA_W-1:0] d0_r,   d0_nxt;
  logic [mrfc_pkg::DATA_W-1:0] d1_r,   d1_nxt;
  logic [CW-1:0]               cnt_r,  cnt_nxt;
  logic [mrfc_pkg::LEN_W-1:0]  held_r, held_nxt;
  logic                        ovf_r,  ovf_nxt;

  logic                        out_valid_r, out_valid_nxt;
  mrfc_pkg::status_t           status_r, status_nxt;
  logic [mrfc_pkg::CRC_W-1:0]  ocrc_r;
  logic [mrfc_pkg::COUNT_W-1:0] ocnt_r;

  logic                        out_free;
  logic                        res_load;
  logic [mrfc_pkg::CRC_W-1:0]  crc_upd;
  logic [CW-1:0]               cnt_upd;
  logic                        ovf_upd;
  logic                        sat;
  logic [mrfc_pkg::CRC_W-1:0]  trailer;

  assign out_free = !out_valid_r || !out_stall;
  assign beat_go  = beat_valid && (!beat.frame_end || out_free);
  assign res_load = beat_go && beat.frame_end;

  always_comb begin
    sat      = (cnt_r == CW'(MAX_FRAME_BYTES));
    crc_upd  = (cnt_r >= CW'(2)) ? mrfc_pkg::crc_byte(crc_r, d1_r) : crc_r;
    cnt_upd  = sat ? cnt_r : CW'(cnt_r + 1'b1);
    ovf_upd  = ovf_r || sat;
    trailer  = {beat.rx_byte, d0_r};

    held_nxt = held_r;
    crc_nxt  = crc_r;
    d0_nxt   = d0_r;
    d1_nxt   = d1_r;
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    if (beat_go) begin
      if (cnt_r == '0) begin
        held_nxt = beat.expected_length;
      end
      if (beat.frame_end) begin
        crc_nxt = mrfc_pkg::CRC_INIT;
        d0_nxt  = '0;
        d1_nxt  = '0;
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end else begin
        crc_nxt = crc_upd;
        d0_nxt  = beat.rx_byte;
        d1_nxt  = d0_r;
        cnt_nxt = cnt_upd;
        ovf_nxt = ovf_upd;
      end
    end
  end

  always_comb begin
    if (ovf_upd || (CMPW'(cnt_upd) != CMPW'(held_nxt)) || (cnt_upd < CW'(2))) begin
      status_nxt = mrfc_pkg::STATUS_LEN_ERR;
    end else if (trailer != crc_upd) begin
      status_nxt = mrfc_pkg::STATUS_CRC_ERR;
    end else begin
      status_nxt = mrfc_pkg::STATUS_GOOD;
    end

    out_valid_nxt = out_valid_r && out_stall;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= mrfc_pkg::CRC_INIT;
      d0_r        <= '0;
      d1_r        <= '0;
      cnt_r       <= '0;
      held_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      crc_r       <= crc_nxt;
      d0_r        <= d0_nxt;
      d1_r        <= d1_nxt;
      cnt_r       <= cnt_nxt;
      held_r      <= held_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status_r <= status_nxt;
      ocrc_r   <= crc_upd;
      ocnt_r   <= mrfc_pkg::COUNT_W'(cnt_upd);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_computed_crc = ocrc_r;
  assign out_byte_count   = ocnt_r;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !res_load)
    else $error("pending result overwritten");

  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> (cnt_r == '0) && (crc_r == mrfc_pkg::CRC_INIT) && !ovf_r)
    else $error("frame state not cleared after last byte");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_FRAME_BYTES))
    else $error("byte count beyond maximum");

  a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (cnt_r == CW'(MAX_FRAME_BYTES)))
    else $error("overflow flag without saturated count");

  a_crc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r < CW'(3)) |-> (crc_r == mrfc_pkg::CRC_INIT))
    else $error("crc advanced before third byte");
`endif

endmodule

FILE: rtl/modbus_rtu_frame_checker.sv
// A beat that ends a frame passes the input register, then the result
// register; it waits longer only while an earlier status is stalled.
// Throughput: 1 byte per cycle except during the stall below; the per-byte
// CRC update is eight unrolled shift/XOR steps on the oldest delayed byte.
// The input side stalls only while a finished status waits on a stalled output.
// Reset (rst_n, synchronous, active low) restores CRC 0xFFFF and clears the
// count, the delay line and the held length.
// ----------------------------------------------------------------------------
// Modbus RTU frame checker
// Streams frame bytes through a CRC-16 (poly 0xA001) and reports one status
// per frame: good, length mismatch or CRC mismatch.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_checker #(
  parameter int unsigned MAX_FRAME_BYTES = mrfc_pkg::MAX_FRAME_BYTES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mrfc_pkg::DATA_W-1:0]   in_rx_byte,
  input  logic                          in_frame_end,
  input  logic [mrfc_pkg::LEN_W-1:0]    in_expected_length,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [mrfc_pkg::CRC_W-1:0]    out_computed_crc,
  output logic [mrfc_pkg::COUNT_W-1:0]  out_byte_count
);

  logic            beat_valid;
  logic            beat_go;
  mrfc_pkg::beat_t beat;

  mrfc_in_reg u_in_reg (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .in_frame_end       (in_frame_end),
    .in_expected_length (in_expected_length),
    .beat_go            (beat_go),
    .beat_valid         (beat_valid),
    .beat               (beat)
  );

  mrfc_frame_eval #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_frame_eval (
    .clk              (clk),
    .rst_n            (rst_n),
    .beat_valid       (beat_valid),
    .beat             (beat),
    .beat_go          (beat_go),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_computed_crc (out_computed_crc),
    .out_byte_count   (out_byte_count)
  );

endmodule

FILE: bench/modbus_rtu_frame_checker_tb.sv
// ----------------------------------------------------------------------------
// Modbus RTU frame checker testbench
// Streams short directed frames, two long frames (the second saturating) and
// random frames until at least 1300 beats are sent, with random gaps and
// stalls on both sides. A local CRC-16 frame model predicts the status, CRC
// and byte count of every frame, and each status beat is compared in order.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_checker_tb;

  typedef logic [mrfc_pkg::DATA_W-1:0] octet_q_t[$];

  typedef struct {
    mrfc_pkg::status_t            status;
    logic [mrfc_pkg::CRC_W-1:0]   crc;
    logic [mrfc_pkg::COUNT_W-1:0] count;
  } frame_result_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic [mrfc_pkg::DATA_W-1:0]  in_rx_byte;
  logic                         in_frame_end;
  logic [mrfc_pkg::LEN_W-1:0]   in_expected_length;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [1:0]                   out_status;
  logic [mrfc_pkg::CRC_W-1:0]   out_computed_crc;
  logic [mrfc_pkg::COUNT_W-1:0] out_byte_count;

  modbus_rtu_frame_checker dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .in_frame_end       (in_frame_end),
    .in_expected_length (in_expected_length),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_computed_crc   (out_computed_crc),
    .out_byte_count     (out_byte_count)
  );

  frame_result_t    frame_result_q[$];
  int unsigned      mismatches = 0;
  int unsigned      beats_sent = 0;
  bit               pace_on = 1'b1;
  int               hold_left = -1;

  // frame model state
  logic [mrfc_pkg::CRC_W-1:0]  crc_acc = mrfc_pkg::CRC_INIT;
  logic [mrfc_pkg::DATA_W-1:0] dly_new = '0;
  logic [mrfc_pkg::DATA_W-1:0] dly_old = '0;
  int unsigned                 byte_tally = 0;
  logic [mrfc_pkg::LEN_W-1:0]  held_len = '0;
  bit                          saturated = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [mrfc_pkg::CRC_W-1:0] crc16_update(
    input logic [mrfc_pkg::CRC_W-1:0]  crc,
    input logic [mrfc_pkg::DATA_W-1:0] b);
    logic fb;
    for (int i = 0; i < mrfc_pkg::DATA_W; i++) begin
      fb  = crc[0] ^ b[i];
      crc = crc >> 1;
      if (fb) crc = crc ^ mrfc_pkg::CRC_POLY;
    end
    return crc;
  endfunction

  function automatic octet_q_t with_crc(input octet_q_t body);
    logic [mrfc_pkg::CRC_W-1:0] c;
    c = mrfc_pkg::CRC_INIT;
    foreach (body[i]) c = crc16_update(c, body[i]);
    body.push_back(c[7:0]);
    body.push_back(c[15:8]);
    return body;
  endfunction

  function automatic octet_q_t random_octets(input int n);
    octet_q_t q;
    for (int i = 0; i < n; i++) q.push_back(mrfc_pkg::DATA_W'($urandom));
    return q;
  endfunction

  function automatic void note_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  task automatic predict_beat(input logic [mrfc_pkg::DATA_W-1:0] b, input logic last,
                              input logic [mrfc_pkg::LEN_W-1:0] len);
    frame_result_t              r;
    logic [mrfc_pkg::CRC_W-1:0] trailer;
    if (byte_tally == 0) held_len = len;
    if (byte_tally >= 2) crc_acc = crc16_update(crc_acc, dly_old);
    dly_old = dly_new;
    dly_new = b;
    if (byte_tally < mrfc_pkg::MAX_FRAME_BYTES) byte_tally++;
    else saturated = 1'b1;
    if (last) begin
      trailer = {dly_new, dly_old};
      if (saturated || byte_tally != held_len || byte_tally < 2)
        r.status = mrfc_pkg::STATUS_LEN_ERR;
      else if (trailer != crc_acc) r.status = mrfc_pkg::STATUS_CRC_ERR;
      else r.status = mrfc_pkg::STATUS_GOOD;
      r.crc   = crc_acc;
      r.count = mrfc_pkg::COUNT_W'(byte_tally);
      frame_result_q.push_back(r);
      crc_acc    = mrfc_pkg::CRC_INIT;
      dly_new    = '0;
      dly_old    = '0;
      byte_tally = 0;
      saturated  = 1'b0;
    end
  endtask

  task automatic send_byte(input logic [mrfc_pkg::DATA_W-1:0] b, input logic last,
                           input logic [mrfc_pkg::LEN_W-1:0] len);
    int gap;
    gap = pace_on ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_rx_byte         <= b;
    in_frame_end       <= last;
    in_expected_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_beat(b, last, len);
    beats_sent++;
    @(negedge clk);
  endtask

  // jumble: drive random lengths on every beat but the first
  task automatic send_frame(input octet_q_t bytes, input logic [mrfc_pkg::LEN_W-1:0] len,
                            input bit jumble);
    foreach (bytes[i]) begin
      send_byte(bytes[i], i == bytes.size() - 1,
                (i == 0 || !jumble) ? len : mrfc_pkg::LEN_W'($urandom));
    end
  endtask

  task automatic test_short_frames();
    send_frame('{8'hA5}, 9'd0, 1'b0);
    send_frame('{8'hFF, 8'hFF}, 9'd2, 1'b0);
  endtask

  task automatic test_good_frames();
    send_frame(with_crc('{8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h0A}), 9'd8, 1'b0);
    send_frame(with_crc('{8'h00, 8'h00}), 9'd4, 1'b0);
  endtask

  task automatic test_length_errors();
    send_frame(with_crc('{8'hFF, 8'hFF}), 9'd511, 1'b0);
  endtask

  task automatic test_crc_errors();
    octet_q_t f;
    f = with_crc('{8'h5A, 8'hC3});
    f[3] ^= 8'h80;
    send_frame(f, 9'd4, 1'b1);
  endtask

  task automatic test_both_wrong();
    send_frame('{8'h12, 8'h34, 8'h56}, 9'd256, 1'b0);
  endtask

  task automatic test_long_frames();
    send_frame(with_crc(random_octets(mrfc_pkg::MAX_FRAME_BYTES - 2)), 9'd256, 1'b1);
    send_frame(with_crc(random_octets(mrfc_pkg::MAX_FRAME_BYTES - 1)), 9'd256, 1'b0);
  endtask

  task automatic test_random_frames(input int unsigned beat_goal);
    octet_q_t                   f;
    logic [mrfc_pkg::LEN_W-1:0] len;
    int                         kind;
    int                         pos;
    while (beats_sent < beat_goal) begin
      pace_on = ($urandom_range(0, 7) != 0);
      kind    = $urandom_range(0, 9);
      if (kind == 9) f = random_octets($urandom_range(1, 12));
      else f = with_crc(random_octets($urandom_range(0, 14)));
      len = mrfc_pkg::LEN_W'(f.size());
      if (kind == 6 || kind == 8 || kind == 9) len = mrfc_pkg::LEN_W'($urandom);
      if (kind == 7 || kind == 8) begin
        pos = f.size() - 1 - $urandom_range(0, 1);
        f[pos] ^= mrfc_pkg::DATA_W'(1 << $urandom_range(0, mrfc_pkg::DATA_W - 1));
      end
      send_frame(f, len, $urandom_range(0, 3) == 0);
    end
    pace_on = 1'b1;
  endtask

  // result side: draw a hold per status beat and stall through it; stall at random between beats
  always @(negedge clk) begin
    if (out_valid === 1'b1) begin
      if (hold_left < 0) hold_left = pace_on ? $urandom_range(0, 6) : 0;
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
        hold_left = -1;
      end
    end else begin
      out_stall <= pace_on && ($urandom_range(0, 3) == 0);
      hold_left = -1;
    end
  end

  always @(posedge clk) begin : check_results
    frame_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_result_q.size() == 0) begin
        note_error($sformatf("unexpected status beat: status %0d crc %h count %0d",
                             out_status, out_computed_crc, out_byte_count));
      end else begin
        e = frame_result_q.pop_front();
        if (out_status !== e.status)
          note_error($sformatf("status exp %0d got %0d", e.status, out_status));
        if (out_computed_crc !== e.crc)
          note_error($sformatf("computed_crc exp %h got %h", e.crc, out_computed_crc));
        if (out_byte_count !== e.count)
          note_error($sformatf("byte_count exp %0d got %0d", e.count, out_byte_count));
      end
    end
  end

  initial begin
    #2000000;
    $display("modbus_rtu_frame_checker_tb: done, errors");
    $finish;
  end

  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_rx_byte         = '0;
    in_frame_end       = 1'b0;
    in_expected_length = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_short_frames();
    test_good_frames();
    test_length_errors();
    test_crc_errors();
    test_both_wrong();
    test_long_frames();
    test_random_frames(1300);

    in_valid <= 1'b0;
    while (frame_result_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("modbus_rtu_frame_checker_tb: done, clean");
    end else begin
      $display("modbus_rtu_frame_checker_tb: done, errors");
    end
    $finish;
  end

endmodule
